// ===== design/assert_macros.svh =====
// Assertion macros used by the voxel face picker controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/vgrp_pkg.sv =====
// Types and constants shared by the voxel face picker modules.
package vgrp_pkg;
  localparam int GridSide    = 8;
  localparam int CellBits    = 3;
  localparam int MapDepth    = GridSide * GridSide * GridSide;
  localparam int MapAddrBits = 3 * CellBits;
  localparam int SampleCount = 100;
  localparam int SampleBits  = 7;
  localparam int FaceTol     = 7;

  localparam logic [2:0] FACE_NEG_X = 3'd0;

  typedef struct packed {
    logic               action;
    logic [2:0]         cell_x;
    logic [2:0]         cell_y;
    logic [2:0]         cell_z;
    logic               cell_solid;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] start_z;
    logic signed [23:0] dir_x;
    logic signed [23:0] dir_y;
    logic signed [23:0] dir_z;
    logic [22:0]        ray_length;
  } item_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] hit_x;
    logic [2:0] hit_y;
    logic [2:0] hit_z;
    logic [2:0] hit_face;
  } result_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;       // capture the ray item
    logic clear_k;    // restart the sample counter
    logic pos_step;   // compute sample position for current k
    logic map_read;   // issue map read
    logic judge;      // evaluate looked-up cell
    logic slab_step;  // process one slab axis
    logic face_step;  // process one face axis
    logic next_k;     // advance sample counter
    logic map_write;  // write one cell
    logic clear_map;  // clearing sweep write
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic last_k;
    logic need_slab;
    logic face_found;
    logic axis_last;
    logic sweep_last;
  } stat_t;
endpackage

// ===== design/vgrp_ram.sv =====
// Generic single-port-write, registered-read RAM.
module vgrp_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/vgrp_datapath.sv =====
// Datapath: sample positions, map store, slab and face tests.
module vgrp_datapath (
  input  logic            clk,
  input  logic            rst,
  input  vgrp_pkg::item_t item,
  input  vgrp_pkg::cmd_t  cmd,
  output vgrp_pkg::stat_t stat,
  output vgrp_pkg::result_t res
);
  import vgrp_pkg::*;

  item_t ray;
  logic [SampleBits-1:0] k;
  logic [1:0] axis;
  logic [MapAddrBits-1:0] sweep;
  logic signed [23:0] s_a, d_a;
  logic signed [47:0] dl [3];
  logic signed [CellBits+1:0] cell_idx [3];
  logic in_grid, air_seen, solid_rd;
  logic signed [31:0] tnum, tden;
  logic have_t;
  logic [2:0] face;
  logic found;
  logic [MapAddrBits-1:0] raddr, waddr;
  logic we, wdata;

  // Per-axis start and direction selected by the axis counter.
  always_comb begin
    case (axis)
      2'd0: begin s_a = ray.start_x; d_a = ray.dir_x; end
      2'd1: begin s_a = ray.start_y; d_a = ray.dir_y; end
      default: begin s_a = ray.start_z; d_a = ray.dir_z; end
    endcase
  end

  // Sample position: one axis per cycle, product d*len held per axis.
  logic signed [79:0] num;
  logic signed [79:0] prod_k;
  logic signed [79:0] q;
  assign prod_k = 80'(dl[axis]) * $signed({1'b0, k});
  assign num = (80'(s_a) <<< 16) * SampleCount + prod_k;
  assign q = num >>> 32;

  // The cell index is floor(q / SampleCount); only indices within the grid matter,
  // so it is found by comparing q against the multiples of SampleCount.
  logic signed [CellBits+1:0] cell_new;
  always_comb begin
    cell_new = '1;
    if (q >= 0 && q < 80'(GridSide * SampleCount)) begin
      cell_new = '0;
      for (int j = 1; j < GridSide; j++) begin
        if (q >= 80'(j * SampleCount)) cell_new = (CellBits+2)'(j);
      end
    end
  end

  // Face error and slab products for the current axis.
  logic signed [31:0] bound, n_a, dn_a, off_a;
  logic signed [63:0] lhs, rhs, e, m;
  assign bound = d_a > 0 ? (32'(cell_idx[axis]) <<< 16)
                         : ((32'(cell_idx[axis]) + 32'sd1) <<< 16);
  assign n_a = d_a > 0 ? bound - 32'(s_a) : 32'(s_a) - bound;
  assign dn_a = d_a < 0 ? -32'(d_a) : 32'(d_a);
  assign off_a = 32'(s_a) - (32'(cell_idx[axis]) <<< 16);
  assign lhs = 64'(n_a) * 64'(tden);
  assign rhs = 64'(tnum) * 64'(dn_a);
  assign e = 64'(off_a) * 64'(tden) + 64'(d_a) * 64'(tnum);
  assign m = e < 0 ? -e : e;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= '0;
      k <= '0;
      air_seen <= 1'b0;
      sweep <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.clear_map) sweep <= sweep + 1'b1;
      if (cmd.load) begin
        ray <= item;
        air_seen <= 1'b0;
        found <= 1'b0;
        axis <= '0;
        dl[0] <= 48'(item.dir_x) * $signed({1'b0, item.ray_length});
        dl[1] <= 48'(item.dir_y) * $signed({1'b0, item.ray_length});
        dl[2] <= 48'(item.dir_z) * $signed({1'b0, item.ray_length});
      end
      if (cmd.clear_k) k <= '0;
      if (cmd.next_k) k <= k + 1'b1;
      if (cmd.pos_step) begin
        cell_idx[axis] <= cell_new;
        axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
      end
      if (cmd.judge) begin
        if (in_grid && !solid_rd) air_seen <= 1'b1;
        have_t <= 1'b0;
        tnum <= '0;
        tden <= 32'sd1;
        face <= FACE_NEG_X;
        axis <= '0;
      end
      if (cmd.slab_step) begin
        if (d_a != 0 && (!have_t || lhs > rhs)) begin
          tnum <= n_a;
          tden <= dn_a;
          have_t <= 1'b1;
        end
        axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
      end
      if (cmd.face_step) begin
        if (!found) begin
          if (m < 64'(FaceTol) * 64'(tden)) begin
            found <= 1'b1; face <= {axis, 1'b0};
          end else if (m > 64'(65536 - FaceTol) * 64'(tden)) begin
            found <= 1'b1; face <= {axis, 1'b1};
          end
        end
        axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
      end
    end
  end

  assign in_grid = cell_idx[0] >= 0 && cell_idx[1] >= 0 && cell_idx[2] >= 0;
  assign raddr = {cell_idx[2][CellBits-1:0], cell_idx[1][CellBits-1:0],
                  cell_idx[0][CellBits-1:0]};
  assign we = cmd.map_write | cmd.clear_map;
  assign waddr = cmd.clear_map ? sweep : {item.cell_z, item.cell_y, item.cell_x};
  assign wdata = cmd.clear_map ? 1'b1 : item.cell_solid;

  vgrp_ram #(.Width(1), .Depth(MapDepth)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(solid_rd)
  );

  assign stat.last_k = (k == SampleBits'(SampleCount - 1));
  assign stat.need_slab = in_grid && solid_rd && air_seen;
  assign stat.face_found = found;
  assign stat.axis_last = (axis == 2'd2);
  assign stat.sweep_last = (sweep == MapAddrBits'(MapDepth - 1));

  assign res.hit = found;
  assign res.hit_x = found ? cell_idx[0][CellBits-1:0] : '0;
  assign res.hit_y = found ? cell_idx[1][CellBits-1:0] : '0;
  assign res.hit_z = found ? cell_idx[2][CellBits-1:0] : '0;
  assign res.hit_face = found ? face : '0;
endmodule

// ===== design/vgrp_ctrl.sv =====
// Controller state machine sequencing the ray march.
module vgrp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            action,
  input  vgrp_pkg::stat_t stat,
  output vgrp_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done,
  output logic            write_done
);
  import vgrp_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_POS   = 9'b000000100,
    S_READ  = 9'b000001000,
    S_JUDGE = 9'b000010000,
    S_SLAB  = 9'b000100000,
    S_FACE  = 9'b001000000,
    S_NEXT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic wr_pulse;

  // Next-state and command decode.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_map = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start && action) begin
          cmd.load = 1'b1; cmd.clear_k = 1'b1; state_next = S_POS;
        end else if (start) begin
          cmd.map_write = 1'b1;
        end
      end
      S_POS: begin
        cmd.pos_step = 1'b1;
        if (stat.axis_last) state_next = S_READ;
      end
      S_READ: begin
        cmd.map_read = 1'b1; state_next = S_JUDGE;
      end
      S_JUDGE: begin
        cmd.judge = 1'b1;
        state_next = stat.need_slab ? S_SLAB : S_NEXT;
      end
      S_SLAB: begin
        cmd.slab_step = 1'b1;
        if (stat.axis_last) state_next = S_FACE;
      end
      S_FACE: begin
        cmd.face_step = 1'b1;
        if (stat.axis_last) state_next = S_NEXT;
      end
      S_NEXT: begin
        if (stat.face_found || stat.last_k) state_next = S_DONE;
        else begin
          cmd.next_k = 1'b1; state_next = S_POS;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      wr_pulse <= 1'b0;
    end else begin
      state <= state_next;
      wr_pulse <= cmd.map_write;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign write_done = wr_pulse;

  `ASSERT_IMPL(a_onehot, clk, rst, 1'b1, $onehot(state))
  `ASSERT_NEXT(a_done_idle, clk, rst, done, state == S_IDLE)
  `ASSERT_IMPL(a_slab_air, clk, rst, cmd.slab_step, stat.need_slab || state == S_SLAB)
endmodule

// ===== design/voxel_grid_ray_face_pick_unit.sv =====
// Top level of the voxel grid ray face picker.
// Usage: drive item and raise start; a transfer is accepted when start is
// high and busy is low. One result per item appears on result for exactly
// one cycle with strobe high; the receiver cannot stall it.
// A write item (action 0) returns a zero result in the cycle after
// acceptance, and busy stays low, so writes can follow every cycle.
// A ray item is marched over up to 100 samples, stopping at the first face
// hit; each sample runs three position axes on one shared multiplier path,
// a map read, a judge and an advance step, and a solid cell behind air adds
// the slab and face axes. The next item can be accepted in the cycle after
// the strobe.
// After reset all 512 map cells are swept to solid; busy stays high
// during the sweep and no item is taken.
module voxel_grid_ray_face_pick_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  vgrp_pkg::item_t     item,
  output logic                busy,
  output logic                strobe,
  output vgrp_pkg::result_t   result
);
  import vgrp_pkg::*;

  cmd_t cmd;
  stat_t stat;
  result_t dp_res;
  logic done, write_done;

  vgrp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(item.action), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done), .write_done(write_done)
  );

  vgrp_datapath u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .stat(stat), .res(dp_res)
  );

  // Result strobe; writes report a zero result.
  assign strobe = done | write_done;
  assign result = done ? dp_res : '0;
endmodule
